FILE: rtl/knc_pkg.sv
`timescale 1ns / 1ps

package knc_pkg;

    localparam int VALUE_BITS     = 16;
    localparam int CLUSTER_BITS   = 3;
    localparam int FEATURE_BITS   = 4;
    localparam int MAX_CLUSTERS   = 8;
    localparam int MAX_FEATURES   = 16;
    localparam int CEN_ADDR_BITS  = CLUSTER_BITS + FEATURE_BITS;
    localparam int CEN_DEPTH      = MAX_CLUSTERS * MAX_FEATURES;
    localparam int DIFF_BITS      = VALUE_BITS + 1;
    localparam int SQ_BITS        = 2 * VALUE_BITS;
    localparam int SUM_BITS       = 37;
    localparam int DIST_BITS      = 36;
    localparam int NC_REG_BITS    = 4;
    localparam int NF_REG_BITS    = 5;
    localparam int CFG_DATA_BITS  = 5;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic MODE_CENTROID = 1'b0;
    localparam logic MODE_SAMPLE   = 1'b1;

    localparam logic [CFG_INDEX_BITS-1:0] REG_CLUSTERS_IN_USE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FEATURES_IN_USE = 1'd1;

    localparam logic [NC_REG_BITS-1:0] CLUSTERS_RESET = 4'd8;
    localparam logic [NF_REG_BITS-1:0] FEATURES_RESET = 5'd16;

    typedef struct packed {
        logic                           mode;
        logic [CLUSTER_BITS-1:0]        cluster_index;
        logic [FEATURE_BITS-1:0]        feature_index;
        logic signed [VALUE_BITS-1:0]   value;
    } sample_t;

    typedef struct packed {
        logic [CLUSTER_BITS-1:0] nearest_cluster;
        logic [DIST_BITS-1:0]    min_distance_sq;
    } result_t;

    typedef struct packed {
        logic                    valid;
        logic [CLUSTER_BITS-1:0] cluster;
        logic                    first;
        logic                    last;
    } issue_t;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_ISSUE
    } seq_state_t;

endpackage

FILE: rtl/knc_centroid_ram.sv
`timescale 1ns / 1ps

module knc_centroid_ram
(
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [knc_pkg::CEN_ADDR_BITS-1:0]      waddr,
    input  logic signed [knc_pkg::VALUE_BITS-1:0]  wdata,
    input  logic [knc_pkg::CEN_ADDR_BITS-1:0]      raddr,
    output logic signed [knc_pkg::VALUE_BITS-1:0]  rdata
);
    import knc_pkg::*;

    logic signed [VALUE_BITS-1:0] mem [CEN_DEPTH];
    logic signed [VALUE_BITS-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/knc_sum_ram.sv
`timescale 1ns / 1ps

module knc_sum_ram
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                clear,
    input  logic                                we,
    input  logic [knc_pkg::CLUSTER_BITS-1:0]    waddr,
    input  logic [knc_pkg::SUM_BITS-1:0]        wdata,
    input  logic [knc_pkg::CLUSTER_BITS-1:0]    raddr,
    output logic [knc_pkg::SUM_BITS-1:0]        rdata
);
    import knc_pkg::*;

    logic [SUM_BITS-1:0]     mem [MAX_CLUSTERS];
    logic [MAX_CLUSTERS-1:0] valid_reg;
    logic [MAX_CLUSTERS-1:0] valid_next;
    logic [SUM_BITS-1:0]     rdata_reg;
    logic                    rvalid_reg;

    // An entry that has not been written since the last clear reads as zero.
    always_comb
    begin
        valid_next = valid_reg;
        if (clear)
        begin
            valid_next = '0;
        end
        else if (we)
        begin
            valid_next[waddr] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            rvalid_reg <= 1'b0;
        end
        else
        begin
            valid_reg  <= valid_next;
            rvalid_reg <= valid_reg[raddr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rvalid_reg ? rdata_reg : '0;

endmodule

FILE: rtl/knc_seq.sv
`timescale 1ns / 1ps

module knc_seq
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             go,
    input  logic [knc_pkg::CLUSTER_BITS-1:0] last_cluster,
    output knc_pkg::issue_t                  issue
);
    import knc_pkg::*;

    seq_state_t              state_reg;
    seq_state_t              state_next;
    logic [CLUSTER_BITS-1:0] k_reg;
    logic [CLUSTER_BITS-1:0] k_next;
    logic [CLUSTER_BITS-1:0] last_reg;
    logic [CLUSTER_BITS-1:0] last_next;
    logic                    at_last;

    assign at_last = (k_reg == last_reg);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (go)
                begin
                    state_next = SEQ_ISSUE;
                end
            end
            SEQ_ISSUE:
            begin
                if (at_last)
                begin
                    state_next = SEQ_IDLE;
                end
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        k_next    = k_reg;
        last_next = last_reg;
        issue     = '0;
        unique case (state_reg)
            SEQ_IDLE:
            begin
                if (go)
                begin
                    k_next    = '0;
                    last_next = last_cluster;
                end
            end
            SEQ_ISSUE:
            begin
                issue.valid   = 1'b1;
                issue.cluster = k_reg;
                issue.first   = (k_reg == '0);
                issue.last    = at_last;
                k_next        = k_reg + 1'b1;
            end
            default:
            begin
                k_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            k_reg     <= '0;
            last_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            last_reg  <= last_next;
        end
    end

endmodule

FILE: rtl/kmeans_nearest_centroid_unit.sv
`timescale 1ns / 1ps

// Nearest-centroid assignment for k-means. A transaction with mode 0 writes one
// centroid element. A transaction with mode 1 carries one sample element;
// feature index 0 starts a new sample. Each such element keeps busy high while
// the centroid memory gives one element a cycle for every cluster in use,
// followed by a three-stage difference, square and accumulate pipeline. Sample
// elements beyond features_in_use are dropped. After the last feature in use,
// done is high for exactly one cycle with the nearest cluster (lower index on
// ties) and its squared distance in Q20.16, saturated to 36 bits; the receiver
// cannot hold this transaction off and must capture it in that cycle.
// Configuration may be written only while busy is low.
module kmeans_nearest_centroid_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  knc_pkg::sample_t                   item,
    output logic                               done,
    output knc_pkg::result_t                   result,
    input  logic                               wr_en,
    input  logic [knc_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [knc_pkg::CFG_DATA_BITS-1:0]  wr_data
);
    import knc_pkg::*;

    logic [NC_REG_BITS-1:0]  clusters_reg;
    logic [NF_REG_BITS-1:0]  features_reg;
    logic [CLUSTER_BITS-1:0] nc_m1;
    logic [FEATURE_BITS-1:0] nf_m1;

    logic accept;
    logic centroid_we;
    logic sample_go;

    logic signed [VALUE_BITS-1:0] value_reg;
    logic [FEATURE_BITS-1:0]      feature_reg;
    logic                         last_elem_reg;

    issue_t issue;
    issue_t p1_reg;
    issue_t p2_reg;
    issue_t p3_reg;

    logic signed [VALUE_BITS-1:0] cen_rdata;
    logic [SUM_BITS-1:0]          sum_rdata;

    logic signed [DIFF_BITS-1:0]   diff_reg;
    logic signed [2*DIFF_BITS-1:0] prod;
    logic [SQ_BITS-1:0]            sq_reg;
    logic [SUM_BITS-1:0]           sum1_reg;
    logic [SUM_BITS-1:0]           sum2_reg;
    logic [SUM_BITS:0]             sum_wide;
    logic [SUM_BITS-1:0]           sum_new;

    logic                    take;
    logic [SUM_BITS-1:0]     best_sum_reg;
    logic [SUM_BITS-1:0]     best_sum_next;
    logic [CLUSTER_BITS-1:0] best_k_reg;
    logic [CLUSTER_BITS-1:0] best_k_next;

    logic    done_reg;
    result_t result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clusters_reg <= CLUSTERS_RESET;
            features_reg <= FEATURES_RESET;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_CLUSTERS_IN_USE: clusters_reg <= wr_data[NC_REG_BITS-1:0];
                REG_FEATURES_IN_USE: features_reg <= wr_data[NF_REG_BITS-1:0];
                default:             ;
            endcase
        end
    end

    // Registers outside their range act as the nearest limit.
    always_comb
    begin
        if (clusters_reg == '0)
        begin
            nc_m1 = '0;
        end
        else if (clusters_reg > NC_REG_BITS'(MAX_CLUSTERS))
        begin
            nc_m1 = CLUSTER_BITS'(MAX_CLUSTERS - 1);
        end
        else
        begin
            nc_m1 = CLUSTER_BITS'(clusters_reg - 1'b1);
        end

        if (features_reg == '0)
        begin
            nf_m1 = '0;
        end
        else if (features_reg > NF_REG_BITS'(MAX_FEATURES))
        begin
            nf_m1 = FEATURE_BITS'(MAX_FEATURES - 1);
        end
        else
        begin
            nf_m1 = FEATURE_BITS'(features_reg - 1'b1);
        end
    end

    assign accept      = start && !busy;
    assign centroid_we = accept && (item.mode == MODE_CENTROID);
    assign sample_go   = accept && (item.mode == MODE_SAMPLE) && (item.feature_index <= nf_m1);

    always_ff @(posedge clk)
    begin
        if (sample_go)
        begin
            value_reg     <= item.value;
            feature_reg   <= item.feature_index;
            last_elem_reg <= (item.feature_index == nf_m1);
        end
    end

    knc_seq u_seq
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .go           (sample_go),
        .last_cluster (nc_m1),
        .issue        (issue)
    );

    knc_centroid_ram u_centroid_ram
    (
        .clk   (clk),
        .we    (centroid_we),
        .waddr ({item.cluster_index, item.feature_index}),
        .wdata (item.value),
        .raddr ({issue.cluster, feature_reg}),
        .rdata (cen_rdata)
    );

    knc_sum_ram u_sum_ram
    (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (sample_go && (item.feature_index == '0)),
        .we    (p3_reg.valid),
        .waddr (p3_reg.cluster),
        .wdata (sum_new),
        .raddr (issue.cluster),
        .rdata (sum_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_reg <= '0;
            p2_reg <= '0;
            p3_reg <= '0;
        end
        else
        begin
            p1_reg <= issue;
            p2_reg <= p1_reg;
            p3_reg <= p2_reg;
        end
    end

    assign prod = diff_reg * diff_reg;

    always_ff @(posedge clk)
    begin
        diff_reg <= DIFF_BITS'(value_reg) - DIFF_BITS'(cen_rdata);
        sum1_reg <= sum_rdata;
        sq_reg   <= prod[SQ_BITS-1:0];
        sum2_reg <= sum1_reg;
    end

    assign sum_wide = {1'b0, sum2_reg} + (SUM_BITS + 1)'(sq_reg);
    assign sum_new  = sum_wide[SUM_BITS] ? '1 : sum_wide[SUM_BITS-1:0];

    assign take          = p3_reg.first || (sum_new < best_sum_reg);
    assign best_sum_next = take ? sum_new : best_sum_reg;
    assign best_k_next   = take ? p3_reg.cluster : best_k_reg;

    always_ff @(posedge clk)
    begin
        if (p3_reg.valid)
        begin
            best_sum_reg <= best_sum_next;
            best_k_reg   <= best_k_next;
        end
        result_reg.nearest_cluster <= best_k_next;
        result_reg.min_distance_sq <= best_sum_next[SUM_BITS-1:DIST_BITS] != '0
                                      ? '1 : best_sum_next[DIST_BITS-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= p3_reg.valid && p3_reg.last && last_elem_reg;
        end
    end

    assign busy   = issue.valid || p1_reg.valid || p2_reg.valid || p3_reg.valid;
    assign done   = done_reg;
    assign result = result_reg;

    a_done_follows_work: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(p3_reg.valid))
        else $error("Result strobe without a finished accumulation.");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("Two results in consecutive cycles.");

    a_centroid_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.mode == MODE_CENTROID) |=> !busy)
        else $error("Centroid write started a sample sequence.");

    a_issue_starts_first: assert property (@(posedge clk) disable iff (!rst_n)
        (issue.valid && !$past(issue.valid)) |-> issue.first)
        else $error("Cluster sweep did not begin at cluster zero.");

endmodule

FILE: verif/knc_checker.sv
`timescale 1ns / 1ps

module knc_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic                               busy,
    input  knc_pkg::sample_t                   item,
    input  logic                               done,
    input  knc_pkg::result_t                   result,
    input  logic                               wr_en,
    input  logic [knc_pkg::CFG_INDEX_BITS-1:0] wr_index,
    input  logic [knc_pkg::CFG_DATA_BITS-1:0]  wr_data,
    output int                                 fails,
    output int                                 pending
);
    import knc_pkg::*;

    logic signed [VALUE_BITS-1:0] centroid_mem [MAX_CLUSTERS][MAX_FEATURES];
    logic [SUM_BITS-1:0]          dist_sum [MAX_CLUSTERS];
    logic [NC_REG_BITS-1:0]       nc_reg;
    logic [NF_REG_BITS-1:0]       nf_reg;
    result_t                      nearest_q [$];

    function automatic int used_clusters();
        if (nc_reg == 0)
        begin
            return 1;
        end
        if (nc_reg > MAX_CLUSTERS)
        begin
            return MAX_CLUSTERS;
        end
        return int'(nc_reg);
    endfunction

    function automatic int used_features();
        if (nf_reg == 0)
        begin
            return 1;
        end
        if (nf_reg > MAX_FEATURES)
        begin
            return MAX_FEATURES;
        end
        return int'(nf_reg);
    endfunction

    task automatic accumulate_element(input sample_t it);
        int                          nc;
        int                          nf;
        int                          best;
        logic signed [DIFF_BITS-1:0] diff;
        logic [DIFF_BITS-1:0]        mag;
        logic [SQ_BITS-1:0]          sq;
        logic [SUM_BITS:0]           acc;
        logic [SUM_BITS-1:0]         low;
        result_t                     nearest;
        nc = used_clusters();
        nf = used_features();
        if (it.mode == MODE_CENTROID)
        begin
            centroid_mem[it.cluster_index][it.feature_index] = it.value;
        end
        else if (int'(it.feature_index) < nf)
        begin
            if (it.feature_index == 0)
            begin
                for (int k = 0; k < MAX_CLUSTERS; k++)
                begin
                    dist_sum[k] = '0;
                end
            end
            for (int k = 0; k < nc; k++)
            begin
                diff = DIFF_BITS'(it.value) - DIFF_BITS'(centroid_mem[k][it.feature_index]);
                mag  = (diff < 0) ? -diff : diff;
                sq   = SQ_BITS'(mag) * SQ_BITS'(mag);
                acc  = {1'b0, dist_sum[k]} + (SUM_BITS + 1)'(sq);
                dist_sum[k] = acc[SUM_BITS] ? {SUM_BITS{1'b1}} : acc[SUM_BITS-1:0];
            end
            if (int'(it.feature_index) == nf - 1)
            begin
                best = 0;
                low  = dist_sum[0];
                for (int k = 1; k < nc; k++)
                begin
                    if (dist_sum[k] < low)
                    begin
                        low  = dist_sum[k];
                        best = k;
                    end
                end
                nearest.nearest_cluster = CLUSTER_BITS'(best);
                if (low > SUM_BITS'({DIST_BITS{1'b1}}))
                begin
                    nearest.min_distance_sq = {DIST_BITS{1'b1}};
                end
                else
                begin
                    nearest.min_distance_sq = low[DIST_BITS-1:0];
                end
                nearest_q.push_back(nearest);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        int      errs;
        errs = 0;
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_CLUSTERS; k++)
            begin
                dist_sum[k] = '0;
                for (int f = 0; f < MAX_FEATURES; f++)
                begin
                    centroid_mem[k][f] = '0;
                end
            end
            nc_reg = CLUSTERS_RESET;
            nf_reg = FEATURES_RESET;
            nearest_q.delete();
            fails   <= 0;
            pending <= 0;
        end
        else
        begin
            if (done)
            begin
                if (nearest_q.size() == 0)
                begin
                    $error("result with no transaction pending: nearest_cluster %0d, distance %0d",
                           result.nearest_cluster, result.min_distance_sq);
                    errs++;
                end
                else
                begin
                    want = nearest_q.pop_front();
                    if (result.nearest_cluster !== want.nearest_cluster)
                    begin
                        $error("nearest_cluster: expected %0d, got %0d",
                               want.nearest_cluster, result.nearest_cluster);
                        errs++;
                    end
                    if (result.min_distance_sq !== want.min_distance_sq)
                    begin
                        $error("min_distance_sq: expected %0d, got %0d",
                               want.min_distance_sq, result.min_distance_sq);
                        errs++;
                    end
                end
            end
            if (wr_en)
            begin
                if (wr_index == REG_CLUSTERS_IN_USE)
                begin
                    nc_reg = wr_data[NC_REG_BITS-1:0];
                end
                else
                begin
                    nf_reg = wr_data[NF_REG_BITS-1:0];
                end
            end
            if (start && !busy)
            begin
                accumulate_element(item);
            end
            fails   <= fails + errs;
            pending <= nearest_q.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import knc_pkg::*;

    localparam int ITEM_TARGET   = 1750;
    localparam int STALL_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 16;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    sample_t                   item;
    logic                      done;
    result_t                   result;
    logic                      wr_en;
    logic [CFG_INDEX_BITS-1:0] wr_index;
    logic [CFG_DATA_BITS-1:0]  wr_data;
    int                        fails;
    int                        pending;
    int                        idle_pct;
    int                        item_count;
    int                        quiet_cycles = 0;
    logic [NC_REG_BITS-1:0]    nc_setting;
    logic [NF_REG_BITS-1:0]    nf_setting;

    always #2 clk = ~clk;

    kmeans_nearest_centroid_unit i_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    knc_checker i_checker
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .item     (item),
        .done     (done),
        .result   (result),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .fails    (fails),
        .pending  (pending)
    );

    function automatic int feature_limit();
        if (nf_setting == 0)
        begin
            return 1;
        end
        if (nf_setting > MAX_FEATURES)
        begin
            return MAX_FEATURES;
        end
        return int'(nf_setting);
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_value();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            default: return VALUE_BITS'($urandom);
        endcase
    endfunction

    task automatic send(input logic m, input logic [CLUSTER_BITS-1:0] c,
                        input logic [FEATURE_BITS-1:0] f, input logic [VALUE_BITS-1:0] v);
        sample_t it;
        it.mode          = m;
        it.cluster_index = c;
        it.feature_index = f;
        it.value         = v;
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy);
        if (m == MODE_CENTROID || int'(f) < feature_limit())
        begin
            item_count++;
        end
    endtask

    task automatic send_element(input int f, input logic [VALUE_BITS-1:0] v);
        send(MODE_SAMPLE, CLUSTER_BITS'($urandom), FEATURE_BITS'(f), v);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy) @(posedge clk);
    endtask

    task automatic set_config(input logic [CFG_DATA_BITS-1:0] nc_data,
                              input logic [CFG_DATA_BITS-1:0] nf_data);
        wr_en    <= 1'b1;
        wr_index <= REG_CLUSTERS_IN_USE;
        wr_data  <= nc_data;
        @(posedge clk);
        wr_index <= REG_FEATURES_IN_USE;
        wr_data  <= nf_data;
        @(posedge clk);
        wr_en    <= 1'b0;
        nc_setting = nc_data[NC_REG_BITS-1:0];
        nf_setting = nf_data;
    endtask

    task automatic random_burst();
        int r;
        int n;
        int part;
        r = $urandom_range(99);
        n = feature_limit();
        if (r < 70)
        begin
            for (int f = 0; f < n; f++)
            begin
                send_element(f, pick_value());
            end
        end
        else if (r < 82)
        begin
            send(MODE_CENTROID, CLUSTER_BITS'($urandom), FEATURE_BITS'($urandom),
                 pick_value());
        end
        else if (r < 92)
        begin
            part = $urandom_range(n - 1);
            for (int f = 0; f < part; f++)
            begin
                send_element(f, pick_value());
            end
        end
        else
        begin
            send_element($urandom_range(MAX_FEATURES - 1), pick_value());
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done || wr_en)
        begin
            quiet_cycles <= 0;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    initial
    begin
        logic [VALUE_BITS-1:0] v;
        rst_n      = 1'b0;
        start      = 1'b0;
        item       = '0;
        wr_en      = 1'b0;
        wr_index   = '0;
        wr_data    = '0;
        idle_pct   = 0;
        item_count = 0;
        nc_setting = CLUSTERS_RESET;
        nf_setting = FEATURES_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Cluster 0 sits at the negative extreme, cluster 1 at the positive one,
        // and clusters 2 and 3 coincide so that a sample at the origin ties.
        for (int c = 0; c < MAX_CLUSTERS; c++)
        begin
            for (int f = 0; f < MAX_FEATURES; f++)
            begin
                if (c == 0)
                    v = 16'h8000;
                else if (c == 1)
                    v = 16'h7fff;
                else if (c < 4)
                    v = 16'h0000;
                else
                    v = VALUE_BITS'($urandom);
                send(MODE_CENTROID, CLUSTER_BITS'(c), FEATURE_BITS'(f), v);
            end
        end

        settle();
        set_config(5'd8, 5'd2);
        send_element(0, 16'h7fff);
        send_element(1, 16'h7fff);
        send_element(0, 16'h0000);
        send_element(1, 16'h0000);
        send_element(3, 16'h5a5a);
        send_element(1, 16'h1234);
        send_element(0, 16'hedcb);
        send_element(1, 16'h8000);

        settle();
        set_config(5'd1, 5'd16);
        for (int f = 0; f < MAX_FEATURES; f++)
        begin
            send_element(f, 16'h7fff);
        end

        for (int phase = 0; item_count < ITEM_TARGET; phase++)
        begin
            settle();
            case (phase)
                0: set_config(5'd8, 5'd1);
                1: set_config(5'd0, 5'd0);
                2: set_config(5'd31, 5'd31);
                3: set_config(5'd5, 5'd3);
                default:
                begin
                    set_config(($urandom_range(99) < 15) ? CFG_DATA_BITS'($urandom)
                                                         : CFG_DATA_BITS'($urandom_range(1, 8)),
                               ($urandom_range(99) < 15) ? CFG_DATA_BITS'($urandom)
                             : ($urandom_range(99) < 10) ? CFG_DATA_BITS'(MAX_FEATURES)
                                                         : CFG_DATA_BITS'($urandom_range(1, 6)));
                end
            endcase
            case (phase % 4)
                1:       idle_pct = 70;
                2:       idle_pct = 6;
                default: idle_pct = 0;
            endcase
            repeat (40) random_burst();
        end

        settle();
        if (fails == 0 && pending == 0)
        begin
            $display("tb OK");
        end
        else
        begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
